// ===== rtl/core/crc_frame_receiver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// CRC frame receiver assertion macros
// Clocked, reset-gated concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define CRC_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define CRCFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same check with the consequent in the cycle after the antecedent.
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CRCFR_ASSERT(label, clk, rst_n, prop, msg)
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/crcfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC frame receiver package
// Result codes, register indexes and the CRC16-CCITT byte update.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam logic [7:0]  MIN_FRAME  = 8'd5;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Register indexes of the write port
    localparam logic [1:0] CFG_SYNC_BYTE = 2'd0;
    localparam logic [1:0] CFG_DEST_BITS = 2'd1;
    localparam logic [1:0] CFG_SEQ_MASK  = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_DEST     = 3'd2,
        ERR_NO_SYNC  = 3'd3,
        ERR_CRC      = 3'd4
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [7:0] seq_number;
        logic [6:0] frame_length;
        err_t       error_code;
    } result_t;

    // Reflected CRC16-CCITT, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
    endfunction

endpackage

// ===== rtl/core/crcfr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC frame receiver stream interfaces
// Byte request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crcfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] seq_number;
    logic [6:0] frame_length;
    logic [2:0] error_code;

    modport source (output valid, output kind, output payload_byte, output seq_number,
                    output frame_length, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input seq_number,
                    input frame_length, input error_code, output ready);
endinterface

// ===== rtl/core/crc_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC frame receiver
// Streaming receiver for sync-terminated link frames with CRC16-CCITT check.
// ----------------------------------------------------------------------------
// The receiver takes one link byte per clock cycle on rx while rx is ready
// and delivers each result through the result register on res. A frame is a
// length byte, a sequence byte, the payload, a CRC16 high byte first, and the
// sync byte; payload bytes come out as they arrive, a bad length or sequence
// byte yields a reject, and the trailer byte an accept (sequence, length)
// or a reject (error code). The CRC byte update and the position compares
// sit between the frame state registers and the result register. A one-entry
// skid register behind the result register keeps rx ready while one result
// waits; rx stalls only when both hold results. After reset the block hunts
// for a sync byte before it takes a length byte; there is no clearing pass.
// The user writes registers through cfg_we / cfg_index / cfg_data only while
// the block is idle; the block does not enforce this. Unknown indexes are ignored.
`include "crc_frame_receiver_unit_assert.svh"

module crc_frame_receiver_unit #(
    parameter int MAX_FRAME = 64      // longest legal frame, 5..127
) (
    input  logic        clk,
    input  logic        rst_n,
    crcfr_rx_if.sink    rx,
    crcfr_res_if.source res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] sync_byte_reg;
    logic [7:0] dest_bits_reg;
    logic [7:0] seq_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= 8'd126;
            dest_bits_reg <= 8'd16;
            seq_mask_reg  <= 8'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crcfr_pkg::CFG_SYNC_BYTE: sync_byte_reg <= cfg_data;
                crcfr_pkg::CFG_DEST_BITS: dest_bits_reg <= cfg_data;
                crcfr_pkg::CFG_SEQ_MASK:  seq_mask_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic        hunting_reg,      hunting_next;
    logic [6:0]  byte_pos_reg,     byte_pos_next;
    logic [6:0]  exp_len_reg,      exp_len_next;
    logic [7:0]  seq_held_reg,     seq_held_next;
    logic [15:0] crc_reg,          crc_next;
    logic [7:0]  crc_high_reg,     crc_high_next;
    logic        mismatch_reg,     mismatch_next;

    // Result register plus skid entry
    crcfr_pkg::result_t out_reg,   out_next;
    logic               out_valid_reg, out_valid_next;
    crcfr_pkg::result_t skid_reg,  skid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               rx_take;
    logic               res_take;
    logic               new_valid;
    crcfr_pkg::result_t new_res;

    logic [7:0]  b;
    logic [7:0]  pos_w;          // byte position, widened for the +3 compares
    logic [7:0]  len_w;
    logic [15:0] crc_upd;
    logic [6:0]  pos_inc;

    assign rx.ready = !skid_valid_reg;
    assign rx_take  = rx.valid && rx.ready;
    assign res_take = out_valid_reg && res.ready;

    assign b       = rx.rx_byte;
    assign pos_w   = {1'b0, byte_pos_reg};
    assign len_w   = {1'b0, exp_len_reg};
    assign crc_upd = crcfr_pkg::crc_update(crc_reg, b);
    assign pos_inc = byte_pos_reg + 7'd1;

    // Per-byte frame decode
    always_comb
    begin
        hunting_next  = hunting_reg;
        byte_pos_next = byte_pos_reg;
        exp_len_next  = exp_len_reg;
        seq_held_next = seq_held_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        mismatch_next = mismatch_reg;
        new_valid     = 1'b0;
        new_res       = '{kind: crcfr_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
                          seq_number: 8'd0, frame_length: 7'd0,
                          error_code: crcfr_pkg::ERR_NONE};

        if (rx_take)
        begin
            if (hunting_reg)
            begin
                if (b == sync_byte_reg)
                begin
                    hunting_next  = 1'b0;
                    byte_pos_next = 7'd0;
                    crc_next      = crcfr_pkg::CRC_INIT;
                    mismatch_next = 1'b0;
                end
            end
            else if (byte_pos_reg == 7'd0)
            begin
                if (b < crcfr_pkg::MIN_FRAME || b > 8'(MAX_FRAME))
                begin
                    new_valid          = 1'b1;
                    new_res.kind       = crcfr_pkg::KIND_REJECT;
                    new_res.error_code = crcfr_pkg::ERR_LENGTH;
                end
                else
                begin
                    exp_len_next  = b[6:0];
                    crc_next      = crc_upd;
                    byte_pos_next = 7'd1;
                end
            end
            else if (byte_pos_reg == 7'd1)
            begin
                if ((b & ~seq_mask_reg) != dest_bits_reg)
                begin
                    new_valid          = 1'b1;
                    new_res.kind       = crcfr_pkg::KIND_REJECT;
                    new_res.error_code = crcfr_pkg::ERR_DEST;
                end
                else
                begin
                    seq_held_next = b & seq_mask_reg;
                    crc_next      = crc_upd;
                    byte_pos_next = 7'd2;
                end
            end
            else if (pos_w + 8'd3 < len_w)
            begin
                // payload byte
                crc_next             = crc_upd;
                byte_pos_next        = pos_inc;
                new_valid            = 1'b1;
                new_res.payload_byte = b;
            end
            else if (pos_w + 8'd3 == len_w)
            begin
                crc_high_next = b;
                byte_pos_next = pos_inc;
            end
            else if (pos_w + 8'd2 == len_w)
            begin
                mismatch_next = {crc_high_reg, b} != crc_reg;
                byte_pos_next = pos_inc;
            end
            else
            begin
                // trailer: sync check goes before the CRC verdict
                new_valid = 1'b1;
                if (b != sync_byte_reg)
                begin
                    new_res.kind       = crcfr_pkg::KIND_REJECT;
                    new_res.error_code = crcfr_pkg::ERR_NO_SYNC;
                end
                else if (mismatch_reg)
                begin
                    new_res.kind       = crcfr_pkg::KIND_REJECT;
                    new_res.error_code = crcfr_pkg::ERR_CRC;
                end
                else
                begin
                    new_res.kind         = crcfr_pkg::KIND_ACCEPT;
                    new_res.seq_number   = seq_held_reg;
                    new_res.frame_length = exp_len_reg;
                    byte_pos_next        = 7'd0;
                    crc_next             = crcfr_pkg::CRC_INIT;
                    mismatch_next        = 1'b0;
                end
            end

            // any reject restarts the hunt after the failing byte
            if (new_valid && new_res.kind == crcfr_pkg::KIND_REJECT)
            begin
                hunting_next  = 1'b1;
                byte_pos_next = 7'd0;
                crc_next      = crcfr_pkg::CRC_INIT;
                mismatch_next = 1'b0;
            end
        end
    end

    // Result register / skid steering. A new result cannot arrive while the
    // skid entry is full, since rx is not ready then.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (res_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (new_valid)
            begin
                out_next = new_res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (new_valid)
        begin
            if (!out_valid_reg)
            begin
                out_next       = new_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = new_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg    <= 1'b1;
            byte_pos_reg   <= 7'd0;
            exp_len_reg    <= 7'd0;
            seq_held_reg   <= 8'd0;
            crc_reg        <= crcfr_pkg::CRC_INIT;
            crc_high_reg   <= 8'd0;
            mismatch_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            hunting_reg    <= hunting_next;
            byte_pos_reg   <= byte_pos_next;
            exp_len_reg    <= exp_len_next;
            seq_held_reg   <= seq_held_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            mismatch_reg   <= mismatch_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.payload_byte = out_reg.payload_byte;
    assign res.seq_number   = out_reg.seq_number;
    assign res.frame_length = out_reg.frame_length;
    assign res.error_code   = out_reg.error_code;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CRCFR_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_reg |-> out_valid_reg, "skid full with result register empty")
    `CRCFR_ASSERT(a_hunt_pos_zero, clk, rst_n, hunting_reg |-> (byte_pos_reg == 7'd0), "hunting with nonzero byte position")
    `CRCFR_ASSERT(a_pos_in_frame, clk, rst_n, (!hunting_reg && byte_pos_reg >= 7'd2) |-> (byte_pos_reg < exp_len_reg), "byte position past frame length")
    `CRCFR_ASSERT_NEXT(a_reject_hunts, clk, rst_n, new_valid && new_res.kind == crcfr_pkg::KIND_REJECT, hunting_reg, "reject did not restart the hunt")

endmodule
